@@ hdl/uvs_pkg.sv @@
// UV sphere query unit: shared types, widths, constants and rounding helper.
// Used by every module of the block; depends on nothing.
package uvs_pkg;

  // Default sphere shape
  localparam int SEGMENTS_DEF = 30;
  localparam int RINGS_DEF    = 15;

  // Field widths
  localparam int IDX_W       = 10;
  localparam int RAD_W       = 16;
  localparam int POS_W       = 17;
  localparam int NRM_W       = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 136;

  // Width for vertex/triangle count arithmetic (holds counts up to 8191)
  localparam int CW = 13;

  // Reciprocal division shift for the segment split
  localparam int DIV_K = 20;

  localparam logic [RAD_W-1:0]        RADIUS_RST = 16'd256;
  localparam logic signed [NRM_W-1:0] NRM_ONE    = 16'sd16384;

  // pi in unsigned Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic {
    OP_VERTEX   = 1'b0,
    OP_TRIANGLE = 1'b1
  } op_e;

  // Per-request bookkeeping carried down the pipe
  typedef struct packed {
    op_e              op;
    logic             ok;        // index in range
    logic             pole_top;
    logic             pole_bot;
    logic             top_cap;
    logic             bot_cap;
    logic             half;      // second triangle of a quad
    logic [IDX_W-1:0] x;         // dividend for the segment split
    logic [IDX_W-1:0] idx;
  } meta_t;

  // Request to the triangle corner logic
  typedef struct packed {
    logic             top_cap;
    logic             bot_cap;
    logic             half;
    logic             seg_last;  // quad sits on the seam
    logic [IDX_W-1:0] quad;      // quad number (first vertex minus one)
    logic [IDX_W-1:0] idx;
  } tri_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] a;
  } corners_t;

  // Shift right by 14, round to nearest, ties away from zero
  function automatic logic signed [32:0] rnd_q14(input logic signed [32:0] v);
    logic [32:0] mag;
    mag = v[32] ? (33'd0 - 33'(v)) : 33'(v);
    mag = (mag + 33'd8192) >> 14;
    return v[32] ? $signed(33'd0 - mag) : $signed(mag);
  endfunction

endpackage

@@ hdl/uvs_trig_rom.sv @@
// UV sphere query unit: constant sine/cosine tables for ring latitude and
// segment longitude, built at elaboration. Depends on uvs_pkg.
module uvs_trig_rom #(
  parameter int SEGMENTS = uvs_pkg::SEGMENTS_DEF,
  parameter int RINGS    = uvs_pkg::RINGS_DEF,
  localparam int TW      = $clog2(RINGS - 1),
  localparam int SW      = $clog2(SEGMENTS)
) (
  input  logic [TW-1:0]                       theta_idx_i,
  input  logic [SW-1:0]                       phi_idx_i,
  output logic signed [uvs_pkg::NRM_W-1:0]    sin_theta_o,
  output logic signed [uvs_pkg::NRM_W-1:0]    cos_theta_o,
  output logic signed [uvs_pkg::NRM_W-1:0]    sin_phi_o,
  output logic signed [uvs_pkg::NRM_W-1:0]    cos_phi_o
);

  localparam int unsigned RingDen    = 2 * RINGS;
  localparam int unsigned TwoRingDen = 4 * RINGS;
  localparam int unsigned SegDen     = 2 * SEGMENTS;
  localparam int unsigned TwoSegDen  = 4 * SEGMENTS;

  // Taylor series to x^13 in Q30, rounded to Q14 and clamped
  function automatic logic signed [15:0] sin_poly(input logic [63:0] a, input logic neg);
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] sum;
    logic [63:0] q;
    a2  = (a * a) >> 30;
    sum = a;
    t   = a;
    t   = ((t * a2) >> 30) / 64'd6;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd20;
    sum = sum + t;
    t   = ((t * a2) >> 30) / 64'd42;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd72;
    sum = sum + t;
    t   = ((t * a2) >> 30) / 64'd110;
    sum = sum - t;
    t   = ((t * a2) >> 30) / 64'd156;
    sum = sum + t;
    q   = (sum + 64'd32768) >> 16;
    if (q > 64'd16384) begin
      q = 64'd16384;
    end
    return neg ? $signed(16'd0 - q[15:0]) : $signed(q[15:0]);
  endfunction

  // sin(pi*num/(2*RINGS))
  function automatic logic signed [15:0] sin_ring(input int unsigned num);
    int unsigned n;
    logic        neg;
    logic [63:0] a;
    n   = num % TwoRingDen;
    neg = 1'b0;
    if (n >= RingDen) begin
      neg = 1'b1;
      n   = n - RingDen;
    end
    if (2 * n > RingDen) begin
      n = RingDen - n;
    end
    a = (uvs_pkg::PI_Q30 * 64'(n)) / RingDen;
    return sin_poly(a, neg);
  endfunction

  // sin(pi*num/(2*SEGMENTS))
  function automatic logic signed [15:0] sin_seg(input int unsigned num);
    int unsigned n;
    logic        neg;
    logic [63:0] a;
    n   = num % TwoSegDen;
    neg = 1'b0;
    if (n >= SegDen) begin
      neg = 1'b1;
      n   = n - SegDen;
    end
    if (2 * n > SegDen) begin
      n = SegDen - n;
    end
    a = (uvs_pkg::PI_Q30 * 64'(n)) / SegDen;
    return sin_poly(a, neg);
  endfunction

  logic signed [uvs_pkg::NRM_W-1:0] sin_theta [2**TW];
  logic signed [uvs_pkg::NRM_W-1:0] cos_theta [2**TW];
  logic signed [uvs_pkg::NRM_W-1:0] sin_phi   [2**SW];
  logic signed [uvs_pkg::NRM_W-1:0] cos_phi   [2**SW];

  // Latitude table, entry e is ring e+1; a full turn keeps the angle positive
  for (genvar e = 0; e < 2**TW; e++) begin : g_theta
    if (e < RINGS - 1) begin : g_on
      localparam int unsigned TNum = 5 * RINGS - 2 * (e + 1);
      localparam logic signed [15:0] SinV = sin_ring(TNum);
      localparam logic signed [15:0] CosV = sin_ring(TNum + RINGS);
      assign sin_theta[e] = SinV;
      assign cos_theta[e] = CosV;
    end else begin : g_off
      assign sin_theta[e] = '0;
      assign cos_theta[e] = '0;
    end
  end

  // Longitude table, entry s is 2*pi*s/SEGMENTS
  for (genvar s = 0; s < 2**SW; s++) begin : g_phi
    if (s < SEGMENTS) begin : g_on
      localparam logic signed [15:0] SinV = sin_seg(4 * s);
      localparam logic signed [15:0] CosV = sin_seg(4 * s + SEGMENTS);
      assign sin_phi[s] = SinV;
      assign cos_phi[s] = CosV;
    end else begin : g_off
      assign sin_phi[s] = '0;
      assign cos_phi[s] = '0;
    end
  end

  assign sin_theta_o = sin_theta[theta_idx_i];
  assign cos_theta_o = cos_theta[theta_idx_i];
  assign sin_phi_o   = sin_phi[phi_idx_i];
  assign cos_phi_o   = cos_phi[phi_idx_i];

endmodule

@@ hdl/uvs_tri_corner.sv @@
// UV sphere query unit: corner indices of one triangle (top fan, quads,
// bottom fan, seam wrap). Combinational. Depends on uvs_pkg.
module uvs_tri_corner #(
  parameter int SEGMENTS = uvs_pkg::SEGMENTS_DEF,
  parameter int RINGS    = uvs_pkg::RINGS_DEF
) (
  input  uvs_pkg::tri_req_t req_i,
  output uvs_pkg::corners_t corners_o
);

  localparam int CW = uvs_pkg::CW;
  localparam int IW = uvs_pkg::IDX_W;

  localparam logic [CW-1:0] SegC     = CW'(SEGMENTS);
  localparam logic [CW-1:0] SegLastC = CW'(SEGMENTS - 1);
  localparam logic [CW-1:0] QuadsC   = CW'(2 * SEGMENTS * (RINGS - 2));
  localparam logic [CW-1:0] BaseC    = CW'(1 + (RINGS - 2) * SEGMENTS);
  localparam logic [CW-1:0] LastVtxC = CW'(SEGMENTS * (RINGS - 1) + 1);

  logic [CW-1:0] idx;
  logic [CW-1:0] tb;
  logic [CW-1:0] up;
  logic [CW-1:0] dn;
  logic [CW-1:0] up_next;
  logic [CW-1:0] dn_next;
  logic [CW-1:0] c0;
  logic [CW-1:0] c1;
  logic [CW-1:0] c2;

  always_comb begin
    idx = CW'(req_i.idx);
    tb  = idx - SegC - QuadsC;
    // quad corners; on the seam the next column is segment 0
    up  = CW'(req_i.quad) + CW'(1);
    dn  = up + SegC;
    if (req_i.seg_last) begin
      dn_next = up + CW'(1);
      up_next = up - SegLastC;
    end else begin
      dn_next = dn + CW'(1);
      up_next = up + CW'(1);
    end

    priority if (req_i.top_cap) begin
      c0 = '0;
      c1 = idx + CW'(1);
      c2 = (idx == SegLastC) ? CW'(1) : idx + CW'(2);
    end else if (req_i.bot_cap) begin
      c0 = BaseC + tb;
      c1 = (tb == SegLastC) ? BaseC : BaseC + tb + CW'(1);
      c2 = LastVtxC;
    end else if (req_i.half) begin
      c0 = up;
      c1 = dn_next;
      c2 = up_next;
    end else begin
      c0 = up;
      c1 = dn;
      c2 = dn_next;
    end

    // indices wrap modulo the field width
    corners_o.a = c0[IW-1:0];
    corners_o.b = c1[IW-1:0];
    corners_o.c = c2[IW-1:0];
  end

endmodule

@@ hdl/uv_sphere_mesh_generator_top.sv @@
// UV sphere query unit, top level: six-stage pipeline, stream ports and the
// radius register. Depends on uvs_pkg, uvs_trig_rom and uvs_tri_corner.
//
// Usage:
//   Requests enter on the s_axis channel: tuser[0] selects a vertex query
//   (0) or a triangle query (1), tdata[9:0] is the vertex or triangle index.
//   Each request gives exactly one result on m_axis: position, unit normal
//   and triangle corners in tdata, valid_res in tuser[0]. Unused fields and
//   all fields of an out-of-range request are zero.
//   The radius (unsigned Q8.8) is written on the cfg channel, which is
//   always ready; write it only while no request is in flight.
//   Throughput: one request per cycle unless the pipe is full and the
//   receiver stalls. Six register stages (index split, reciprocal multiply,
//   remainder fix-up, table lookup, normal multiply, radius multiply), the
//   first of which loads at the accepting edge.
//   Each stage carries its own valid bit and moves whenever the stage after
//   it is empty or moving, so a stalled receiver holds the result steady and
//   s_axis_tready stays high until every stage is full and m_axis_tready is low.
//   Reset (rst_ni low) empties the pipe and sets the radius to 1.0.
module uv_sphere_mesh_generator_top #(
  parameter int SEGMENTS = uvs_pkg::SEGMENTS_DEF,
  parameter int RINGS    = uvs_pkg::RINGS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request: tdata = item_index[9:0]; tuser = operation
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [uvs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  // result: tdata = pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
  //   corner_a, corner_b, corner_c (low to high); tuser = valid_res
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [uvs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [0:0]                        m_axis_tuser,
  // radius register write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [uvs_pkg::RAD_W-1:0]         cfg_data_i
);

  localparam int IW    = uvs_pkg::IDX_W;
  localparam int CW    = uvs_pkg::CW;
  localparam int NW    = uvs_pkg::NRM_W;
  localparam int PW    = uvs_pkg::POS_W;
  localparam int DivK  = uvs_pkg::DIV_K;
  localparam int TW    = $clog2(RINGS - 1);
  localparam int SW    = $clog2(SEGMENTS);
  localparam int RW    = IW + 7;
  localparam int NSTG  = 6;

  localparam logic [CW-1:0]   SegC    = CW'(SEGMENTS);
  localparam logic [CW-1:0]   QuadEnd = CW'(SEGMENTS + 2 * SEGMENTS * (RINGS - 2));
  localparam logic [CW-1:0]   NumVtx  = CW'(SEGMENTS * (RINGS - 1) + 2);
  localparam logic [CW-1:0]   NumTri  = CW'(2 * SEGMENTS * (RINGS - 1));
  localparam logic [DivK-1:0] RecipM  = DivK'((2**DivK) / SEGMENTS);
  localparam logic [RW-1:0]   SegR    = RW'(SEGMENTS);

  // ---------------------------------------------------------------- control
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] vld_d;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d[0] = s_axis_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // radius register
  logic [uvs_pkg::RAD_W-1:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= uvs_pkg::RADIUS_RST;
    end else if (cfg_valid_i) begin
      radius_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------- stage 1
  // range checks, region decode, dividend for the segment split
  uvs_pkg::meta_t meta1_d, meta1_q;
  logic [IW-1:0]  idx_in;
  logic [CW-1:0]  idx_w;
  logic [CW-1:0]  tq;

  always_comb begin
    idx_in           = s_axis_tdata[IW-1:0];
    idx_w            = CW'(idx_in);
    tq               = idx_w - SegC;
    meta1_d.op       = uvs_pkg::op_e'(s_axis_tuser[0]);
    meta1_d.idx      = idx_in;
    meta1_d.pole_top = (idx_w == '0);
    meta1_d.pole_bot = (idx_w == NumVtx - CW'(1));
    meta1_d.top_cap  = (idx_w < SegC);
    meta1_d.bot_cap  = !(idx_w < QuadEnd);
    meta1_d.half     = tq[0];
    unique case (meta1_d.op)
      uvs_pkg::OP_VERTEX: begin
        meta1_d.ok = (idx_w < NumVtx);
        meta1_d.x  = idx_in - IW'(1);
      end
      uvs_pkg::OP_TRIANGLE: begin
        meta1_d.ok = (idx_w < NumTri);
        meta1_d.x  = tq[IW:1];
      end
      default: begin
        meta1_d.ok = 1'b0;
        meta1_d.x  = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------- stage 2
  // multiply by the reciprocal of SEGMENTS
  uvs_pkg::meta_t      meta2_q;
  logic [IW+DivK-1:0]  prod2_d, prod2_q;

  assign prod2_d = (IW + DivK)'(meta1_q.x) * (IW + DivK)'(RecipM);

  // ---------------------------------------------------------------- stage 3
  // quotient estimate is low by at most one: fix with one compare/subtract
  uvs_pkg::meta_t meta3_q;
  logic [IW-1:0]  q0;
  logic [RW-1:0]  rem;
  logic [IW-1:0]  qd3_d, qd3_q;
  logic [SW-1:0]  rm3_d, rm3_q;

  always_comb begin
    q0  = prod2_q[DivK +: IW];
    rem = RW'(meta2_q.x) - RW'(q0) * SegR;
    if (rem >= SegR) begin
      qd3_d = q0 + IW'(1);
      rm3_d = SW'(rem - SegR);
    end else begin
      qd3_d = q0;
      rm3_d = SW'(rem);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // trig table lookup and triangle corners
  uvs_pkg::meta_t              meta4_q;
  logic signed [NW-1:0]        st_d, ct_d, sp_d, cp_d;
  logic signed [NW-1:0]        st4_q, ct4_q, sp4_q, cp4_q;
  uvs_pkg::tri_req_t           tri_req;
  uvs_pkg::corners_t           corners_d, corners4_q;

  uvs_trig_rom #(
    .SEGMENTS (SEGMENTS),
    .RINGS    (RINGS)
  ) u_trig_rom (
    .theta_idx_i (qd3_q[TW-1:0]),
    .phi_idx_i   (rm3_q),
    .sin_theta_o (st_d),
    .cos_theta_o (ct_d),
    .sin_phi_o   (sp_d),
    .cos_phi_o   (cp_d)
  );

  always_comb begin
    tri_req.top_cap  = meta3_q.top_cap;
    tri_req.bot_cap  = meta3_q.bot_cap;
    tri_req.half     = meta3_q.half;
    tri_req.seg_last = (rm3_q == SW'(SEGMENTS - 1));
    tri_req.quad     = meta3_q.x;
    tri_req.idx      = meta3_q.idx;
  end

  uvs_tri_corner #(
    .SEGMENTS (SEGMENTS),
    .RINGS    (RINGS)
  ) u_tri_corner (
    .req_i     (tri_req),
    .corners_o (corners_d)
  );

  // ---------------------------------------------------------------- stage 5
  // normal = (cos phi * cos theta, sin theta, sin phi * cos theta)
  logic signed [32:0]   mx, mz;
  logic signed [32:0]   rx, rz;
  logic signed [NW-1:0] nx5_d, ny5_d, nz5_d;
  logic signed [NW-1:0] nx5_q, ny5_q, nz5_q;
  uvs_pkg::corners_t    corners5_d, corners5_q;
  logic                 ok5_q;

  always_comb begin
    mx         = 33'(cp4_q) * 33'(ct4_q);
    mz         = 33'(sp4_q) * 33'(ct4_q);
    rx         = uvs_pkg::rnd_q14(mx);
    rz         = uvs_pkg::rnd_q14(mz);
    nx5_d      = '0;
    ny5_d      = '0;
    nz5_d      = '0;
    corners5_d = '0;
    priority if (!meta4_q.ok) begin
      // out of range: everything stays zero
    end else if (meta4_q.op == uvs_pkg::OP_TRIANGLE) begin
      corners5_d = corners4_q;
    end else if (meta4_q.pole_top) begin
      ny5_d = uvs_pkg::NRM_ONE;
    end else if (meta4_q.pole_bot) begin
      ny5_d = -uvs_pkg::NRM_ONE;
    end else begin
      nx5_d = rx[NW-1:0];
      ny5_d = st4_q;
      nz5_d = rz[NW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 6
  // position = radius * normal; output register
  logic signed [32:0]   px, py, pz;
  logic signed [PW-1:0] px6_d, py6_d, pz6_d;
  logic signed [PW-1:0] px6_q, py6_q, pz6_q;
  logic signed [NW-1:0] nx6_q, ny6_q, nz6_q;
  uvs_pkg::corners_t    corners6_q;
  logic                 ok6_q;

  always_comb begin
    px    = 33'($signed({1'b0, radius_q})) * 33'(nx5_q);
    py    = 33'($signed({1'b0, radius_q})) * 33'(ny5_q);
    pz    = 33'($signed({1'b0, radius_q})) * 33'(nz5_q);
    px6_d = PW'(uvs_pkg::rnd_q14(px));
    py6_d = PW'(uvs_pkg::rnd_q14(py));
    pz6_d = PW'(uvs_pkg::rnd_q14(pz));
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      meta1_q <= meta1_d;
    end
    if (en[1]) begin
      meta2_q <= meta1_q;
      prod2_q <= prod2_d;
    end
    if (en[2]) begin
      meta3_q <= meta2_q;
      qd3_q   <= qd3_d;
      rm3_q   <= rm3_d;
    end
    if (en[3]) begin
      meta4_q    <= meta3_q;
      st4_q      <= st_d;
      ct4_q      <= ct_d;
      sp4_q      <= sp_d;
      cp4_q      <= cp_d;
      corners4_q <= corners_d;
    end
    if (en[4]) begin
      nx5_q      <= nx5_d;
      ny5_q      <= ny5_d;
      nz5_q      <= nz5_d;
      corners5_q <= corners5_d;
      ok5_q      <= meta4_q.ok;
    end
    if (en[5]) begin
      px6_q      <= px6_d;
      py6_q      <= py6_d;
      pz6_q      <= pz6_d;
      nx6_q      <= nx5_q;
      ny6_q      <= ny5_q;
      nz6_q      <= nz5_q;
      corners6_q <= corners5_q;
      ok6_q      <= ok5_q;
    end
  end

  // ---------------------------------------------------------------- outputs
  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {7'b0, corners6_q.c, corners6_q.b, corners6_q.a,
                          nz6_q, ny6_q, nx6_q, pz6_q, py6_q, px6_q};
  assign m_axis_tuser  = ok6_q;

endmodule

@@ hdl/uvs_checker.sv @@
// UV sphere query unit: port-level checker and its bind to the top level.
// Depends on uvs_pkg and uv_sphere_mesh_generator_top.
module uvs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [uvs_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input logic [0:0]                        m_axis_tuser
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // an out-of-range request returns all zeros
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("invalid result carries data");

  // a triangle result carries no geometry
  a_tri_no_geom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[128:99] != '0) |-> m_axis_tdata[98:0] == '0)
    else $error("triangle result carries position or normal");

  // normal y stays within the unit range
  a_norm_y_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      ($signed(m_axis_tdata[82:67]) <= 16'sd16384) &&
      ($signed(m_axis_tdata[82:67]) >= -16'sd16384))
    else $error("normal y out of range");

endmodule

bind uv_sphere_mesh_generator_top uvs_checker u_uvs_checker (.*);
